// ===== hdl/dqs_pkg.sv =====
// ----------------------------------------------------------------------------
// dqs_pkg
// Shared types, request and status codes, and cell commands for the bounded
// deque with membership search.
// ----------------------------------------------------------------------------
`default_nettype none

package dqs_pkg;

  // Number of entries the store can hold.
  localparam int CAPACITY = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int IDX_W    = $clog2(CAPACITY);

  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [IDX_W-1:0] idx_t;

  // Request kinds.
  localparam logic [2:0] REQ_PUSH_FRONT = 3'd0;
  localparam logic [2:0] REQ_PUSH_BACK  = 3'd1;
  localparam logic [2:0] REQ_POP_FRONT  = 3'd2;
  localparam logic [2:0] REQ_POP_BACK   = 3'd3;
  localparam logic [2:0] REQ_CONTAINS   = 3'd4;
  localparam logic [2:0] REQ_PUSH_UNIQ  = 3'd5;
  localparam logic [2:0] REQ_REMOVE_ALL = 3'd6;

  // Result status codes.
  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_FULL    = 2'd1;
  localparam logic [1:0] STAT_EMPTY   = 2'd2;
  localparam logic [1:0] STAT_PRESENT = 2'd3;

  // Commands broadcast to every cell of the chain.
  localparam logic [2:0] CELL_HOLD       = 3'd0;
  localparam logic [2:0] CELL_PUSH_FRONT = 3'd1;
  localparam logic [2:0] CELL_APPEND     = 3'd2;
  localparam logic [2:0] CELL_SHIFT_DOWN = 3'd3;
  localparam logic [2:0] CELL_ROTATE     = 3'd4;

  // The slot field names the cell that an append writes, or the tail cell
  // that takes the head value during a rotation.
  typedef struct packed {
    logic [2:0] op;
    cnt_t       slot;
  } cell_cmd_t;

  typedef struct packed {
    logic [2:0]         req_type;
    logic signed [31:0] value;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic       found;
    logic [4:0] entry_count;
    logic [4:0] removed_count;
  } rsp_t;

  // Fits an internal count into a 5-bit result field.
  function automatic logic [4:0] cnt_to_field(cnt_t x);
    logic [CNT_W+4:0] t;
    t = {5'b0, x};
    return t[4:0];
  endfunction

endpackage

`default_nettype wire

// ===== hdl/dqs_cell.sv =====
// ----------------------------------------------------------------------------
// dqs_cell
// One storage cell of the deque chain. It holds one entry and loads from its
// neighbors, the head of the chain or the request value on command.
// ----------------------------------------------------------------------------
`default_nettype none

module dqs_cell import dqs_pkg::*; (
  input  wire logic        clk,
  input  wire cell_cmd_t   cmd,
  input  wire idx_t        index,
  input  wire logic [31:0] from_left,
  input  wire logic [31:0] from_right,
  input  wire logic [31:0] head,
  input  wire logic [31:0] value,
  output logic [31:0]      data
);

  logic [31:0] entry;
  logic [31:0] entry_next;
  logic        at_slot;

  assign at_slot = (cnt_t'(index) == cmd.slot);

  always_comb begin
    entry_next = entry;
    case (cmd.op)
      CELL_PUSH_FRONT: begin
        entry_next = (index == '0) ? value : from_left;
      end
      CELL_APPEND: begin
        if (at_slot) begin
          entry_next = value;
        end
      end
      CELL_SHIFT_DOWN: begin
        entry_next = from_right;
      end
      CELL_ROTATE: begin
        // The tail of the live region takes the head; the rest move down.
        entry_next = at_slot ? head : from_right;
      end
      default: begin
        entry_next = entry;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

  assign data = entry;

endmodule

`default_nettype wire

// ===== hdl/bounded_deque_with_search.sv =====
// ----------------------------------------------------------------------------
// bounded_deque_with_search
// Ordered store of signed 32-bit values with push and pop at both ends,
// membership test, push-if-absent and order-keeping remove-all.
// ----------------------------------------------------------------------------
// A request is taken on a clock edge where start is high and busy is low, and
// its result appears on rsp, marked by done, for exactly one cycle; the
// receiver cannot stall, so it must capture rsp whenever done is high. Push
// front, push back, pop front, pop back and the unused request code never
// raise busy: done rises in the next cycle, so such requests can be issued
// back to back. Contains, push-if-absent and remove-all on a non-empty
// store hold busy high through the scan state, which visits each stored
// entry, and the finish state; done rises in the same cycle that busy
// falls. Their length is set by the scan: the entries rotate through the
// chain of cells one position per cycle and the single comparator at the
// front of the chain sees each entry once. On an empty store these three
// requests do not raise busy either. After reset the store is empty; the
// cell contents need no clearing because only entries below the count are
// ever read.
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_deque_with_search import dqs_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  output logic      busy,
  input  wire req_t req,
  output logic      done,
  output rsp_t      rsp
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  localparam cnt_t FULL_COUNT = cnt_t'(CAPACITY);

  // Control registers.
  logic [1:0]  state;
  logic [1:0]  state_next;
  cnt_t        count;
  cnt_t        count_next;
  cnt_t        len;
  cnt_t        len_next;
  cnt_t        steps;
  cnt_t        steps_next;
  logic        found;
  logic        found_next;
  logic        done_next;

  // Payload registers of the pending search.
  logic [2:0]  kind;
  logic [2:0]  kind_next;
  logic [31:0] key;
  logic [31:0] key_next;
  rsp_t        rsp_next;

  // Chain of cells.
  cell_cmd_t   cmd;
  logic [31:0] cell_data [CAPACITY];
  logic [31:0] cell_value;
  logic        head_match;

  // Outside idle the cells see the saved key; in idle, the new request.
  assign cell_value = (state == ST_IDLE) ? req.value : key;
  assign head_match = (cell_data[0] == key);

  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      logic [31:0] left_d;
      logic [31:0] right_d;

      if (gi == 0) begin : g_first
        assign left_d = cell_value;
      end else begin : g_inner_l
        assign left_d = cell_data[gi-1];
      end

      if (gi == CAPACITY - 1) begin : g_last
        assign right_d = cell_data[gi];
      end else begin : g_inner_r
        assign right_d = cell_data[gi+1];
      end

      dqs_cell u_cell (
        .clk        (clk),
        .cmd        (cmd),
        .index      (idx_t'(gi)),
        .from_left  (left_d),
        .from_right (right_d),
        .head       (cell_data[0]),
        .value      (cell_value),
        .data       (cell_data[gi])
      );
    end
  endgenerate

  always_comb begin
    state_next = state;
    count_next = count;
    len_next   = len;
    steps_next = steps;
    found_next = found;
    kind_next  = kind;
    key_next   = key;
    done_next  = 1'b0;
    rsp_next   = rsp;
    cmd.op     = CELL_HOLD;
    cmd.slot   = count;

    case (state)
      ST_IDLE: begin
        if (start) begin
          done_next = 1'b1;
          rsp_next  = '0;
          case (req.req_type)
            REQ_PUSH_FRONT: begin
              if (count == FULL_COUNT) begin
                rsp_next.status = STAT_FULL;
              end else begin
                cmd.op     = CELL_PUSH_FRONT;
                count_next = count + 1'b1;
              end
            end
            REQ_PUSH_BACK: begin
              if (count == FULL_COUNT) begin
                rsp_next.status = STAT_FULL;
              end else begin
                cmd.op     = CELL_APPEND;
                count_next = count + 1'b1;
              end
            end
            REQ_POP_FRONT: begin
              if (count == '0) begin
                rsp_next.status = STAT_EMPTY;
              end else begin
                cmd.op     = CELL_SHIFT_DOWN;
                count_next = count - 1'b1;
              end
            end
            REQ_POP_BACK: begin
              if (count == '0) begin
                rsp_next.status = STAT_EMPTY;
              end else begin
                count_next = count - 1'b1;
              end
            end
            REQ_CONTAINS, REQ_PUSH_UNIQ, REQ_REMOVE_ALL: begin
              if (count == '0) begin
                // Nothing to search: a push-if-absent simply appends.
                if (req.req_type == REQ_PUSH_UNIQ) begin
                  cmd.op     = CELL_APPEND;
                  count_next = count + 1'b1;
                end
              end else begin
                done_next  = 1'b0;
                state_next = ST_SCAN;
                len_next   = count;
                steps_next = count;
                found_next = 1'b0;
                kind_next  = req.req_type;
                key_next   = req.value;
              end
            end
            default: begin
              cmd.op = CELL_HOLD;
            end
          endcase
          rsp_next.entry_count = cnt_to_field(count_next);
        end
      end

      ST_SCAN: begin
        // The head leaves the front each cycle. A kept entry goes to the
        // tail of the live region; a removed one is dropped and the live
        // region shrinks by one.
        if (kind == REQ_REMOVE_ALL && head_match) begin
          cmd.op   = CELL_SHIFT_DOWN;
          len_next = len - 1'b1;
        end else begin
          cmd.op   = CELL_ROTATE;
          cmd.slot = len - 1'b1;
        end
        found_next = found | head_match;
        steps_next = steps - 1'b1;
        if (steps == cnt_t'(1)) begin
          state_next = ST_FINISH;
        end
      end

      ST_FINISH: begin
        done_next  = 1'b1;
        state_next = ST_IDLE;
        rsp_next   = '0;
        case (kind)
          REQ_CONTAINS: begin
            rsp_next.found = found;
          end
          REQ_PUSH_UNIQ: begin
            rsp_next.found = found;
            if (found) begin
              rsp_next.status = STAT_PRESENT;
            end else if (count == FULL_COUNT) begin
              rsp_next.status = STAT_FULL;
            end else begin
              cmd.op     = CELL_APPEND;
              count_next = count + 1'b1;
            end
          end
          REQ_REMOVE_ALL: begin
            count_next             = len;
            rsp_next.removed_count = cnt_to_field(count - len);
          end
          default: begin
            rsp_next.found = 1'b0;
          end
        endcase
        rsp_next.entry_count = cnt_to_field(count_next);
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
      len   <= '0;
      steps <= '0;
      found <= 1'b0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      len   <= len_next;
      steps <= steps_next;
      found <= found_next;
      done  <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    kind <= kind_next;
    key  <= key_next;
    rsp  <= rsp_next;
  end

  assign busy = (state != ST_IDLE);

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the bounded deque with membership search. Requests
// come from a prepared list. A driver issues them with random gaps, and a
// monitor predicts each result from a shadow copy of the store. Every strobed
// response is then checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
  import dqs_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // The package leaves request code 7 unnamed. The block must treat it as a
  // no-op that reports the current count.
  localparam logic [2:0] REQ_UNUSED = 3'd7;

  // Idle styles for the driver: no gaps at all, uniform random gaps, or
  // mostly back to back with a short hiccup now and then.
  localparam int GAPS_NONE   = 0;
  localparam int GAPS_WIDE   = 1;
  localparam int GAPS_SPARSE = 2;

  localparam int RANDOM_REQUESTS = 1450;

  typedef struct {
    req_t        cmd;
    int unsigned gap;   // idle cycles before this request goes out
  } queued_req_t;

  logic clk   = 1'b0;
  logic rst   = 1'b1;
  logic start = 1'b0;
  req_t req   = '0;
  logic busy;
  logic done;
  rsp_t rsp;

  bounded_deque_with_search DUT (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .req   (req),
    .done  (done),
    .rsp   (rsp)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Hold reset from time zero, then release it on a falling edge, like every
  // other input.
  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
  end

  // Safety net. The slowest legal run is about 1450 requests, each with its accept
  // cycle, its busy scan and finish states and its longest idle gap.
  // This timeout allows about ten times that.
  initial begin
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Stimulus generation
  // --------------------------------------------------------------------------
  queued_req_t  outgoing_reqs[$];
  int           gap_mode = GAPS_WIDE;
  logic [31:0]  value_pool[6];

  // The pool holds the signed extremes, zero, minus one and two values that
  // change per scenario. Drawing from it often makes duplicates likely, so
  // searches hit and remove-all deletes more than one entry.
  function automatic logic [31:0] pick_value();
    if ($urandom_range(0, 9) < 7)
      return value_pool[$urandom_range(0, 5)];
    return $urandom;
  endfunction

  function automatic int unsigned draw_gap();
    case (gap_mode)
      GAPS_NONE: return 0;
      GAPS_WIDE: return $urandom_range(0, 12);
      default:   return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : 0;
    endcase
  endfunction

  // An even mix of the seven real requests, with the unused code showing up
  // now and then.
  function automatic logic [2:0] any_request();
    int r;
    r = $urandom_range(0, 49);
    if (r == 0)
      return REQ_UNUSED;
    return 3'(r % 7);
  endfunction

  task automatic add_req(logic [2:0] kind, logic [31:0] v);
    queued_req_t q;
    q.cmd.req_type = kind;
    q.cmd.value    = v;
    q.gap          = draw_gap();
    outgoing_reqs.push_back(q);
  endtask

  // --------------------------------------------------------------------------
  // Driver: it presents one request at a time. start stays high until the
  // monitor counts the request as taken (start high, busy low at a rising
  // edge). It then moves straight on to the next one or idles for that
  // request's gap.
  // --------------------------------------------------------------------------
  int n_issued   = 0;
  int n_accepted = 0;

  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!start || n_accepted == n_issued) begin
      if (outgoing_reqs.size() == 0) begin
        start <= 1'b0;
      end else if (outgoing_reqs[0].gap != 0) begin
        outgoing_reqs[0].gap = outgoing_reqs[0].gap - 1;
        start <= 1'b0;
      end else begin
        req      <= outgoing_reqs[0].cmd;
        start    <= 1'b1;
        n_issued = n_issued + 1;
        void'(outgoing_reqs.pop_front());
      end
    end
  end

  // --------------------------------------------------------------------------
  // Prediction: a shadow of the store with the front at index 0. Entries at
  // or above shadow_count are never read.
  // --------------------------------------------------------------------------
  logic [31:0] shadow_entries[CAPACITY];
  int          shadow_count = 0;

  function automatic rsp_t deque_step(req_t r);
    rsp_t        o;
    logic [31:0] v;
    logic        hit;
    int          kept;
    o    = '0;
    v    = r.value;
    hit  = 1'b0;
    kept = 0;
    for (int i = 0; i < shadow_count; i++)
      if (shadow_entries[i] == v)
        hit = 1'b1;
    case (r.req_type)
      REQ_PUSH_FRONT: begin
        if (shadow_count >= CAPACITY) begin
          o.status = STAT_FULL;
        end else begin
          for (int i = shadow_count; i > 0; i--)
            shadow_entries[i] = shadow_entries[i-1];
          shadow_entries[0] = v;
          shadow_count++;
        end
      end
      REQ_PUSH_BACK: begin
        if (shadow_count >= CAPACITY) begin
          o.status = STAT_FULL;
        end else begin
          shadow_entries[shadow_count] = v;
          shadow_count++;
        end
      end
      REQ_POP_FRONT: begin
        if (shadow_count == 0) begin
          o.status = STAT_EMPTY;
        end else begin
          for (int i = 0; i + 1 < shadow_count; i++)
            shadow_entries[i] = shadow_entries[i+1];
          shadow_count--;
        end
      end
      REQ_POP_BACK: begin
        if (shadow_count == 0)
          o.status = STAT_EMPTY;
        else
          shadow_count--;
      end
      REQ_CONTAINS: begin
        o.found = hit;
      end
      REQ_PUSH_UNIQ: begin
        if (hit) begin
          o.found  = 1'b1;
          o.status = STAT_PRESENT;
        end else if (shadow_count >= CAPACITY) begin
          o.status = STAT_FULL;
        end else begin
          shadow_entries[shadow_count] = v;
          shadow_count++;
        end
      end
      REQ_REMOVE_ALL: begin
        // Survivors slide toward the front and keep their order.
        for (int i = 0; i < shadow_count; i++) begin
          if (shadow_entries[i] != v) begin
            shadow_entries[kept] = shadow_entries[i];
            kept++;
          end
        end
        o.removed_count = 5'(shadow_count - kept);
        shadow_count    = kept;
      end
      default: begin
      end
    endcase
    o.entry_count = 5'(shadow_count);
    return o;
  endfunction

  // --------------------------------------------------------------------------
  // Monitor: it samples at the rising edge. A response strobed by done is
  // checked against the oldest outstanding prediction. A request taken at
  // this edge gets its prediction queued behind the others.
  // --------------------------------------------------------------------------
  rsp_t awaited_rsp[$];
  int   errors = 0;

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : watch
    rsp_t want;
    if (!rst) begin
      if (done) begin
        if (awaited_rsp.size() == 0) begin
          $display("%0t: unexpected response, expected none, got %p", $time, rsp);
          errors++;
        end else begin
          want = awaited_rsp.pop_front();
          check_field("status",        want.status,        rsp.status);
          check_field("found",         want.found,         rsp.found);
          check_field("entry_count",   want.entry_count,   rsp.entry_count);
          check_field("removed_count", want.removed_count, rsp.removed_count);
        end
      end
      if (start && !busy) begin
        awaited_rsp.push_back(deque_step(req));
        n_accepted++;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Test sequence: the directed requests first, then random scenarios. The
  // whole list is built before reset ends. After that this block only waits
  // for the run to drain.
  // --------------------------------------------------------------------------
  initial begin : sequencer
    int total;
    int pick;
    logic [31:0] fill_value;
    logic        one_value;

    value_pool[0] = 32'h8000_0000;
    value_pool[1] = 32'h7fff_ffff;
    value_pool[2] = 32'h0000_0000;
    value_pool[3] = 32'hffff_ffff;
    value_pool[4] = $urandom;
    value_pool[5] = $urandom;

    // Directed part. Pops, contains, remove-all and the unused code run on an
    // empty store first: pops report empty, and contains and remove-all find nothing.
    gap_mode = GAPS_WIDE;
    add_req(REQ_POP_FRONT,  32'h0);
    add_req(REQ_POP_BACK,   32'hffff_ffff);
    add_req(REQ_CONTAINS,   32'h0);
    add_req(REQ_REMOVE_ALL, 32'h0);
    add_req(REQ_UNUSED,     32'h5a5a_5a5a);
    // Both ends, with the signed extremes, zero and minus one.
    add_req(REQ_PUSH_FRONT, 32'h8000_0000);
    add_req(REQ_PUSH_BACK,  32'h7fff_ffff);
    add_req(REQ_PUSH_FRONT, 32'hffff_ffff);
    add_req(REQ_PUSH_BACK,  32'h0000_0000);
    add_req(REQ_CONTAINS,   32'h7fff_ffff);
    add_req(REQ_CONTAINS,   32'h0000_0005);
    // Push-if-absent of a present value is skipped. An absent value is
    // appended.
    add_req(REQ_PUSH_UNIQ,  32'hffff_ffff);
    add_req(REQ_PUSH_UNIQ,  32'h1234_5678);
    // Duplicate minus one, then remove both copies. A value with no match
    // removes nothing.
    add_req(REQ_PUSH_BACK,  32'hffff_ffff);
    add_req(REQ_REMOVE_ALL, 32'hffff_ffff);
    add_req(REQ_REMOVE_ALL, 32'h0000_002a);
    add_req(REQ_POP_FRONT,  32'h0);
    add_req(REQ_POP_BACK,   32'h0);
    add_req(REQ_UNUSED,     32'ha5a5_a5a5);
    add_req(REQ_CONTAINS,   32'h1234_5678);

    // Random part. It is built from scenarios, each with its own idle style
    // and fresh pool values.
    while (outgoing_reqs.size() < RANDOM_REQUESTS) begin
      gap_mode      = $urandom_range(GAPS_NONE, GAPS_SPARSE);
      value_pool[4] = $urandom;
      value_pool[5] = $urandom;
      pick          = $urandom_range(0, 9);
      if (pick < 4) begin
        // A free mix that lets the count wander.
        repeat ($urandom_range(8, 30))
          add_req(any_request(), pick_value());
      end else if (pick < 6) begin
        // Drain past empty, fill past full, then probe and sweep the full
        // store. When every push carries one value, the last remove-all
        // deletes a full store at once.
        one_value  = 1'($urandom_range(0, 1));
        fill_value = pick_value();
        repeat (CAPACITY + 2)
          add_req($urandom_range(0, 1) ? REQ_POP_FRONT : REQ_POP_BACK, $urandom);
        repeat (CAPACITY + 2)
          add_req($urandom_range(0, 1) ? REQ_PUSH_FRONT : REQ_PUSH_BACK,
                  one_value ? fill_value : pick_value());
        add_req(REQ_PUSH_UNIQ,  $urandom);
        add_req(REQ_PUSH_UNIQ,  fill_value);
        add_req(REQ_CONTAINS,   fill_value);
        add_req(REQ_REMOVE_ALL, fill_value);
      end else if (pick < 9) begin
        // Search-heavy traffic on pool values, with a few appends so that
        // there is something to find.
        repeat ($urandom_range(10, 25)) begin
          case ($urandom_range(0, 3))
            0: add_req(REQ_CONTAINS,   pick_value());
            1: add_req(REQ_PUSH_UNIQ,  pick_value());
            2: add_req(REQ_REMOVE_ALL, pick_value());
            default: add_req(REQ_PUSH_BACK, pick_value());
          endcase
        end
      end else begin
        // Noise: any code, fully random values.
        repeat ($urandom_range(3, 8))
          add_req(3'($urandom_range(0, 7)), $urandom);
      end
    end

    total = outgoing_reqs.size();
    wait (!rst);
    while (n_accepted != total)
      @(posedge clk);
    while (awaited_rsp.size() != 0)
      @(posedge clk);
    // Wait longer than a scan of a full store takes, to catch any stray
    // response.
    repeat (CAPACITY + 4) @(posedge clk);
    if (errors == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/dqs_pkg.sv
hdl/dqs_cell.sv
hdl/bounded_deque_with_search.sv
sim/tb.sv
